// File: src/epr_pkg.sv
// Package with the constants, codes and types of the echo and ping responder.
package epr_pkg;

   // Words in one stored reply and in one outgoing ping.
   localparam int PAYLOAD_WORDS = 4;
   // Bits of answer history that are kept.
   localparam int HISTORY_BITS = 64;

   // Index into the reply buffer, and a count that can hold the word total itself.
   localparam int IDX_W = (PAYLOAD_WORDS > 1) ? $clog2(PAYLOAD_WORDS) : 1;
   localparam int CNT_W = $clog2(PAYLOAD_WORDS + 1);

   // Register indexes of the configuration port.
   localparam logic [2:0] CSR_PEER_ADDRESS = 3'd0;
   localparam logic [2:0] CSR_PING_PERIOD  = 3'd1;
   localparam logic [2:0] CSR_REQUEST_TYPE = 3'd2;
   localparam logic [2:0] CSR_REPLY_TYPE   = 3'd3;
   localparam logic [2:0] CSR_SERVICE_ID   = 3'd4;

   // Reset values of the configuration registers.
   localparam logic [15:0] PEER_ADDRESS_RST = 16'd0;
   localparam logic [15:0] PING_PERIOD_RST  = 16'd1000;
   localparam logic [7:0]  REQUEST_TYPE_RST = 8'd0;
   localparam logic [7:0]  REPLY_TYPE_RST   = 8'd1;
   localparam logic [7:0]  SERVICE_ID_RST   = 8'd0;

   // Input commands.
   typedef enum logic [1:0] {
      CMD_TICK = 2'd0,
      CMD_BEAT = 2'd1,
      CMD_READ = 2'd2
   } command_type;

   // Result kinds.
   typedef enum logic [2:0] {
      KIND_NONE  = 3'd0,
      KIND_REPLY = 3'd1,
      KIND_PING  = 3'd2,
      KIND_PONG  = 3'd3,
      KIND_WRONG = 3'd4
   } kind_type;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_REPLY,
      ST_PING
   } state_type;

endpackage

// File: src/epr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module epr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port, and a read port whose data holds while no read is issued.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/echo_ping_responder_core.sv
// Top level of the echo and ping responder: control, counters and the reply buffer.
//
//  channel  | ports                         | carries
//  ---------+-------------------------------+------------------------------------------
//  request  | req_valid / req_stall / req_* | one tick, one incoming beat or one read
//  response | rsp_valid / rsp_stall / rsp_* | one outgoing word or one status word
//  config   | csr_we / csr_index / csr_wdata| one register write
//
// A tick, a beat or a read with nothing to send leaves the controller idle; a pong loads its status
// word in the cycle of acceptance.
// For a stored reply, the first read of the reply buffer RAM is issued in the cycle after
// acceptance and its data arrives in the cycle after that.
// Reset is synchronous and clears all control state; the reply buffer is not cleared.
// With rsp_valid high, a high rsp_stall holds the output word, pauses any emission and stalls new requests.
module echo_ping_responder_core
   import epr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [7:0]  req_payload_type,
   input  logic [15:0] req_src_addr,
   input  logic [7:0]  req_from_service,
   input  logic [3:0]  req_beat_index,
   input  logic [31:0] req_payload_word,
   input  logic        req_beat_last,
   // Response channel.
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_kind,
   output logic [15:0] rsp_to_addr,
   output logic [7:0]  rsp_dst_service,
   output logic [7:0]  rsp_out_type,
   output logic [31:0] rsp_out_word,
   output logic        rsp_last_beat,
   output logic [31:0] rsp_lost_count,
   output logic [31:0] rsp_sent_count,
   output logic [63:0] rsp_history,
   output logic [15:0] rsp_round_trip,
   // Configuration port.
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   // Configuration registers.
   logic [15:0] peer_addr_ff;
   logic [15:0] period_ff;
   logic [7:0]  req_type_ff;
   logic [7:0]  rep_type_ff;
   logic [7:0]  service_id_ff;

   // Control state.
   state_type         state_ff, state_in;
   logic              pending_ff, pending_in;
   logic [15:0]       countdown_ff, countdown_in;
   logic [31:0]       lost_ff, lost_in;
   logic [31:0]       sent_ff, sent_in;
   logic [HISTORY_BITS-1:0] hist_ff, hist_in;
   logic [CNT_W-1:0]  rd_cnt_ff, rd_cnt_in;
   logic              rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]  out_cnt_ff, out_cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Payload registers.
   logic [15:0] reply_addr_ff, reply_addr_in;
   logic [7:0]  reply_svc_ff, reply_svc_in;
   kind_type    rsp_kind_ff, rsp_kind_in;
   logic [15:0] rsp_addr_ff, rsp_addr_in;
   logic [7:0]  rsp_svc_ff, rsp_svc_in;
   logic [7:0]  rsp_type_ff, rsp_type_in;
   logic [31:0] rsp_word_ff, rsp_word_in;
   logic        rsp_last_ff, rsp_last_in;
   logic [15:0] rsp_rtt_ff, rsp_rtt_in;

   // Decode and handshake signals.
   command_type cmd;
   logic        req_acc;
   logic        out_free;
   logic        is_request;
   logic        is_reply;
   logic        pong_match;
   logic        ping_due;
   logic        in_range;
   logic        load_last;
   logic        pong_load;
   logic        rd_issue;
   logic        ram_we;
   logic [31:0] ram_rdata;

   assign cmd        = command_type'(req_command);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = !(state_ff == ST_IDLE && out_free);
   assign req_acc    = req_valid && !req_stall;
   assign is_request = (req_payload_type == req_type_ff);
   assign is_reply   = !is_request && (req_payload_type == rep_type_ff) &&
                       (peer_addr_ff != 16'd0) && (peer_addr_ff == req_src_addr) &&
                       (req_beat_index == 4'd0);
   assign pong_match = (req_payload_word == sent_ff) && !hist_ff[0];
   assign ping_due   = (peer_addr_ff != 16'd0) && (countdown_ff == 16'd0);
   assign in_range   = (32'(req_beat_index) < PAYLOAD_WORDS);
   assign ram_we     = req_acc && (cmd == CMD_BEAT) && is_request && in_range;

   // Reply buffer: written by request beats, read back word by word.
   epr_ram #(
      .WIDTH (32),
      .DEPTH (PAYLOAD_WORDS)
   ) u_reply_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (req_beat_index[IDX_W-1:0]),
      .wr_data (req_payload_word),
      .rd_en   (rd_issue),
      .rd_addr (rd_cnt_ff[IDX_W-1:0]),
      .rd_data (ram_rdata)
   );

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         peer_addr_ff  <= PEER_ADDRESS_RST;
         period_ff     <= PING_PERIOD_RST;
         req_type_ff   <= REQUEST_TYPE_RST;
         rep_type_ff   <= REPLY_TYPE_RST;
         service_id_ff <= SERVICE_ID_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PEER_ADDRESS: peer_addr_ff  <= csr_wdata;
            CSR_PING_PERIOD:  period_ff     <= csr_wdata;
            CSR_REQUEST_TYPE: req_type_ff   <= csr_wdata[7:0];
            CSR_REPLY_TYPE:   rep_type_ff   <= csr_wdata[7:0];
            CSR_SERVICE_ID:   service_id_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc && cmd == CMD_READ) begin
               if (pending_ff) begin
                  state_in = ST_REPLY;
               end else if (ping_due) begin
                  state_in = ST_PING;
               end
            end
         end
         ST_REPLY, ST_PING: begin
            if (load_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and output word for each state.
   always_comb begin
      pending_in    = pending_ff;
      countdown_in  = countdown_ff;
      lost_in       = lost_ff;
      sent_in       = sent_ff;
      hist_in       = hist_ff;
      rd_cnt_in     = rd_cnt_ff;
      rd_vld_in     = rd_vld_ff;
      out_cnt_in    = out_cnt_ff;
      reply_addr_in = reply_addr_ff;
      reply_svc_in  = reply_svc_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_kind_in   = rsp_kind_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_svc_in    = rsp_svc_ff;
      rsp_type_in   = rsp_type_ff;
      rsp_word_in   = rsp_word_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_rtt_in    = rsp_rtt_ff;
      load_last     = 1'b0;
      pong_load     = 1'b0;
      rd_issue      = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               case (cmd)
                  CMD_TICK: begin
                     if (countdown_ff != 16'd0) begin
                        countdown_in = countdown_ff - 16'd1;
                     end
                  end
                  CMD_BEAT: begin
                     if (is_request) begin
                        reply_addr_in = req_src_addr;
                        reply_svc_in  = req_from_service;
                        if (req_beat_last) begin
                           pending_in = 1'b1;
                        end
                     end else if (is_reply) begin
                        // A pong yields one status word, matched or not.
                        rsp_valid_in = 1'b1;
                        rsp_addr_in  = 16'd0;
                        rsp_svc_in   = 8'd0;
                        rsp_type_in  = 8'd0;
                        rsp_word_in  = 32'd0;
                        rsp_last_in  = 1'b1;
                        if (pong_match) begin
                           pong_load   = 1'b1;
                           lost_in     = lost_ff - 32'd1;
                           hist_in     = hist_ff | HISTORY_BITS'(1);
                           rsp_kind_in = KIND_PONG;
                           rsp_rtt_in  = period_ff - countdown_ff;
                        end else begin
                           rsp_kind_in = KIND_WRONG;
                           rsp_rtt_in  = 16'd0;
                        end
                     end
                  end
                  CMD_READ: begin
                     rd_cnt_in  = '0;
                     rd_vld_in  = 1'b0;
                     out_cnt_in = '0;
                     if (pending_ff) begin
                        pending_in = 1'b0;
                     end else if (ping_due) begin
                        lost_in      = lost_ff + 32'd1;
                        sent_in      = sent_ff + 32'd1;
                        hist_in      = hist_ff << 1;
                        countdown_in = period_ff;
                     end else begin
                        // Nothing to send.
                        rsp_valid_in = 1'b1;
                        rsp_kind_in  = KIND_NONE;
                        rsp_addr_in  = 16'd0;
                        rsp_svc_in   = 8'd0;
                        rsp_type_in  = 8'd0;
                        rsp_word_in  = 32'd0;
                        rsp_last_in  = 1'b1;
                        rsp_rtt_in   = 16'd0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_REPLY: begin
            // Move one buffered word into the output register.
            if (out_free && rd_vld_ff) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_REPLY;
               rsp_addr_in  = reply_addr_ff;
               rsp_svc_in   = reply_svc_ff;
               rsp_type_in  = rep_type_ff;
               rsp_word_in  = ram_rdata;
               rsp_last_in  = (out_cnt_ff == IDX_W'(PAYLOAD_WORDS - 1));
               rsp_rtt_in   = 16'd0;
               load_last    = rsp_last_in;
               out_cnt_in   = out_cnt_ff + IDX_W'(1);
               rd_vld_in    = 1'b0;
            end
            // Keep the RAM read one word ahead of the output register.
            if ((rd_cnt_ff < CNT_W'(PAYLOAD_WORDS)) && (!rd_vld_ff || (out_free && rd_vld_ff))) begin
               rd_issue  = 1'b1;
               rd_cnt_in = rd_cnt_ff + CNT_W'(1);
               rd_vld_in = 1'b1;
            end
         end
         ST_PING: begin
            // Word zero carries the sent count, the rest are zero.
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_PING;
               rsp_addr_in  = peer_addr_ff;
               rsp_svc_in   = service_id_ff;
               rsp_type_in  = req_type_ff;
               rsp_word_in  = (out_cnt_ff == '0) ? sent_ff : 32'd0;
               rsp_last_in  = (out_cnt_ff == IDX_W'(PAYLOAD_WORDS - 1));
               rsp_rtt_in   = 16'd0;
               load_last    = rsp_last_in;
               out_cnt_in   = out_cnt_ff + IDX_W'(1);
            end
         end
         default: ;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pending_ff   <= 1'b0;
         countdown_ff <= 16'd0;
         lost_ff      <= 32'd0;
         sent_ff      <= 32'd0;
         hist_ff      <= '0;
         rd_cnt_ff    <= '0;
         rd_vld_ff    <= 1'b0;
         out_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         reply_addr_ff <= 16'd0;
         reply_svc_ff  <= 8'd0;
      end else begin
         state_ff     <= state_in;
         pending_ff   <= pending_in;
         countdown_ff <= countdown_in;
         lost_ff      <= lost_in;
         sent_ff      <= sent_in;
         hist_ff      <= hist_in;
         rd_cnt_ff    <= rd_cnt_in;
         rd_vld_ff    <= rd_vld_in;
         out_cnt_ff   <= out_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         reply_addr_ff <= reply_addr_in;
         reply_svc_ff  <= reply_svc_in;
      end
   end

   // Output word registers.
   always_ff @(posedge clock) begin
      rsp_kind_ff <= rsp_kind_in;
      rsp_addr_ff <= rsp_addr_in;
      rsp_svc_ff  <= rsp_svc_in;
      rsp_type_ff <= rsp_type_in;
      rsp_word_ff <= rsp_word_in;
      rsp_last_ff <= rsp_last_in;
      rsp_rtt_ff  <= rsp_rtt_in;
   end

   // Counters are shown directly from their registers, not sampled with the output word.
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_to_addr     = rsp_addr_ff;
   assign rsp_dst_service = rsp_svc_ff;
   assign rsp_out_type    = rsp_type_ff;
   assign rsp_out_word    = rsp_word_ff;
   assign rsp_last_beat   = rsp_last_ff;
   assign rsp_lost_count  = lost_ff;
   assign rsp_sent_count  = sent_ff;
   assign rsp_history     = 64'(hist_ff);
   assign rsp_round_trip  = rsp_rtt_ff;

`ifndef SYNTHESIS
   // Buffered read data always belongs to a read that was issued.
   a_rd_vld_issued: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REPLY && rd_vld_ff) |-> (rd_cnt_ff != '0))
      else $error("reply data valid without an issued read");

   // A finished reply leaves nothing pending.
   a_reply_clears_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REPLY && load_last) |=> (!pending_ff && state_ff == ST_IDLE))
      else $error("reply pending after its emission");

   // A matched pong marks the newest ping as answered.
   a_pong_sets_history: assert property (@(posedge clock) disable iff (reset)
      pong_load |=> hist_ff[0])
      else $error("history bit not set after a matched pong");

   // Starting a ping advances the sent count by one.
   a_ping_counts: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && state_in == ST_PING) |=> (sent_ff == $past(sent_ff) + 32'd1))
      else $error("sent count not advanced by a ping");
`endif

endmodule
